// ===== design/tipm_pkg.sv =====
package tipm_pkg;

    localparam int LEN_W    = 6;
    localparam int STATUS_W = 3;
    localparam int SYM_W    = 8;

    localparam logic [STATUS_W-1:0] ST_ADVANCED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_IS_WORD    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MISS       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SLOTS_FULL = 3'd3;
    localparam logic [STATUS_W-1:0] ST_POOL_FULL  = 3'd4;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    typedef struct packed {
        logic load;
        logic base;
        logic fetch;
        logic check;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic dropped;
        logic done;
        logic out_busy;
    } t_sts;

endpackage

// ===== design/tipm_ctrl.sv =====
module tipm_ctrl
    import tipm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BASE  = 3'd1;
    localparam logic [2:0] S_PRIME = 3'd2;
    localparam logic [2:0] S_FETCH = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_BASE;
                end
            end
            S_BASE: begin
                o_cmd.base = 1'b1;
                n_state    = i_sts.dropped ? S_OUT : S_PRIME;
            end
            S_PRIME: begin
                n_state = S_FETCH;
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_sts.done ? S_OUT : S_FETCH;
            end
            S_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one command at once");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> !i_sts.out_busy)
        else $error("result emitted over a waiting result");

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == S_BASE)
        else $error("accepted item did not start");

endmodule

// ===== design/tipm_dpath.sv =====
module tipm_dpath
    import tipm_pkg::*;
#(
    parameter int NODE_COUNT   = 16384,
    parameter int EDGE_SLOTS   = 27,
    parameter int MAX_WORD_LEN = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic                i_func,
    input  logic [SYM_W-1:0]    i_symbol,
    input  logic                i_last,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [LEN_W-1:0]    o_prefix_len
);

    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int FREE_W     = $clog2(NODE_COUNT + 1);
    localparam int SLOT_W     = (EDGE_SLOTS > 1) ? $clog2(EDGE_SLOTS) : 1;
    localparam int LINK_DEPTH = NODE_COUNT * EDGE_SLOTS;
    localparam int ADDR_W     = $clog2(LINK_DEPTH);
    localparam int NODE_DW    = SYM_W + NODE_W + SLOT_W;
    localparam int COUNT_CAP  = (MAX_WORD_LEN > 63) ? 63 : MAX_WORD_LEN;

    // node record: char, parent node, parent slot (back link validates a child link)
    logic [NODE_W-1:0]  link_mem [LINK_DEPTH];
    logic [NODE_DW-1:0] node_mem [NODE_COUNT];
    logic               word_mem [NODE_COUNT];

    logic                r_func;
    logic [SYM_W-1:0]    r_symbol;
    logic                r_last;
    logic [NODE_W-1:0]   r_cursor;
    logic [FREE_W-1:0]   r_free;
    logic                r_dropped;
    logic [LEN_W-1:0]    r_count;
    logic [SLOT_W-1:0]   r_k;
    logic [ADDR_W-1:0]   r_addr;
    logic [ADDR_W-1:0]   r_cur_addr;
    logic [NODE_W-1:0]   r_link_rd;
    logic [NODE_W-1:0]   r_chk_link;
    logic                r_link_ok;
    logic [NODE_DW-1:0]  r_node_rd;
    logic                r_word_rd;
    logic [STATUS_W-1:0] r_status;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [LEN_W-1:0]    r_out_len;

    logic [SYM_W-1:0]    node_char;
    logic [NODE_W-1:0]   node_parent;
    logic [SLOT_W-1:0]   node_slot;
    logic                slot_valid;
    logic                slot_match;
    logic                is_insert;
    logic                pool_full;
    logic                last_slot;
    logic                chk_done;
    logic                chk_adv;
    logic                chk_drop;
    logic                chk_claim;
    logic [STATUS_W-1:0] chk_status;
    logic [NODE_W-1:0]   chk_dest;
    logic                word_we;
    logic                word_wd;
    logic [NODE_W-1:0]   word_wa;
    logic [NODE_W-1:0]   free_node;

    assign node_char   = r_node_rd[NODE_DW-1 -: SYM_W];
    assign node_parent = r_node_rd[SLOT_W +: NODE_W];
    assign node_slot   = r_node_rd[SLOT_W-1:0];
    assign free_node   = r_free[NODE_W-1:0];
    assign is_insert   = (r_func == FUNC_INSERT);
    assign pool_full   = (r_free == FREE_W'(NODE_COUNT));
    assign last_slot   = (r_k == SLOT_W'(EDGE_SLOTS - 1));
    assign slot_valid  = r_link_ok && (node_parent == r_cursor) && (node_slot == r_k);
    assign slot_match  = slot_valid && (node_char == r_symbol);

    always_comb begin
        chk_done   = 1'b0;
        chk_adv    = 1'b0;
        chk_drop   = 1'b0;
        chk_claim  = 1'b0;
        chk_status = ST_MISS;
        chk_dest   = r_chk_link;
        if (slot_match) begin
            chk_done   = 1'b1;
            chk_adv    = 1'b1;
            chk_status = ((is_insert && r_last) || r_word_rd) ? ST_IS_WORD : ST_ADVANCED;
        end else if (!slot_valid) begin
            chk_done = 1'b1;
            if (!is_insert) begin
                chk_drop   = 1'b1;
                chk_status = ST_MISS;
            end else if (pool_full) begin
                chk_drop   = 1'b1;
                chk_status = ST_POOL_FULL;
            end else begin
                chk_adv    = 1'b1;
                chk_claim  = 1'b1;
                chk_dest   = free_node;
                chk_status = r_last ? ST_IS_WORD : ST_ADVANCED;
            end
        end else if (last_slot) begin
            chk_done   = 1'b1;
            chk_drop   = 1'b1;
            chk_status = is_insert ? ST_SLOTS_FULL : ST_MISS;
        end
    end

    assign word_we = i_cmd.check && (chk_claim || (slot_match && is_insert && r_last));
    assign word_wd = chk_claim ? r_last : 1'b1;
    assign word_wa = chk_claim ? free_node : r_chk_link;

    always_ff @(posedge i_clk) begin
        if (i_cmd.check && chk_claim) begin
            link_mem[r_cur_addr] <= free_node;
        end
        r_link_rd <= link_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.check && chk_claim) begin
            node_mem[free_node] <= {r_symbol, r_cursor, r_k};
        end
        r_node_rd <= node_mem[r_link_rd];
    end

    always_ff @(posedge i_clk) begin
        if (word_we) begin
            word_mem[word_wa] <= word_wd;
        end
        r_word_rd <= word_mem[r_link_rd];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func   <= i_func;
            r_symbol <= i_symbol;
            r_last   <= i_last;
        end
        if (i_cmd.base) begin
            r_addr   <= ADDR_W'(r_cursor * EDGE_SLOTS);
            r_k      <= '0;
            r_status <= ST_MISS;
        end
        if (i_cmd.fetch) begin
            r_cur_addr <= r_addr;
            r_addr     <= r_addr + ADDR_W'(1);
            r_chk_link <= r_link_rd;
            // a link never written counts as an empty slot
            if ((r_link_rd != '0) && (FREE_W'(r_link_rd) < r_free)) begin
                r_link_ok <= 1'b1;
            end else begin
                r_link_ok <= 1'b0;
            end
        end
        if (i_cmd.check) begin
            if (chk_done) begin
                r_status <= chk_status;
            end else begin
                r_k <= r_k + SLOT_W'(1);
            end
        end
        if (i_cmd.emit) begin
            r_out_status <= r_status;
            r_out_len    <= r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor    <= '0;
            r_free      <= FREE_W'(1);
            r_dropped   <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load && (r_count < LEN_W'(COUNT_CAP))) begin
                r_count <= r_count + LEN_W'(1);
            end
            if (i_cmd.check) begin
                if (chk_adv) begin
                    r_cursor <= chk_dest;
                end
                if (chk_drop) begin
                    r_dropped <= 1'b1;
                end
                if (chk_claim) begin
                    r_free <= r_free + FREE_W'(1);
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                if (r_last) begin
                    r_cursor  <= '0;
                    r_dropped <= 1'b0;
                    r_count   <= '0;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.dropped  = r_dropped;
    assign o_sts.done     = chk_done;
    assign o_sts.out_busy = r_out_valid && i_out_stall;

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_prefix_len = r_out_len;

    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free != '0) && (r_free <= FREE_W'(NODE_COUNT)))
        else $error("pool pointer out of range");

    a_cursor_claimed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        FREE_W'(r_cursor) < r_free)
        else $error("cursor points at an unclaimed node");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LEN_W'(COUNT_CAP))
        else $error("character count above cap");

    a_claim_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.check && chk_claim) |=> r_free == $past(r_free) + FREE_W'(1))
        else $error("claim did not advance the pool");

endmodule

// ===== design/trie_insert_prefix_match.sv =====
// an accepted character goes through BASE, PRIME, then FETCH and CHECK per child slot
// scanned (1..EDGE_SLOTS), then OUT; a character of an already dropped word goes
// from BASE to OUT; a new character is taken only in IDLE, once the last result is
// emitted; OUT waits on the output stall; each slot reads its link, then its record
// reset: synchronous active low, returns to the root with an empty dictionary at once;
// the link store needs no clearing, each child record holds its parent and slot
module trie_insert_prefix_match
    import tipm_pkg::*;
#(
    parameter int NODE_COUNT   = 16384,
    parameter int EDGE_SLOTS   = 27,
    parameter int MAX_WORD_LEN = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_func,
    input  logic [SYM_W-1:0]    i_symbol,
    input  logic                i_last,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [LEN_W-1:0]    o_prefix_len
);

    t_cmd cmd;
    t_sts sts;

    tipm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tipm_dpath #(
        .NODE_COUNT   (NODE_COUNT),
        .EDGE_SLOTS   (EDGE_SLOTS),
        .MAX_WORD_LEN (MAX_WORD_LEN)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_func       (i_func),
        .i_symbol     (i_symbol),
        .i_last       (i_last),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_prefix_len (o_prefix_len)
    );

endmodule

// ===== tb/sv/trie_insert_prefix_match_tb.sv =====
`timescale 1ns / 1ps

module trie_insert_prefix_match_tb
    import tipm_pkg::*;
();

    localparam int NODE_COUNT   = 16384;
    localparam int EDGE_SLOTS   = 27;
    localparam int MAX_WORD_LEN = 32;
    localparam int CYCLE_LIMIT  = 8000000;
    localparam int STORE_DEPTH  = 32;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [LEN_W-1:0]    prefix_len;
    } t_outcome;

    typedef logic [SYM_W-1:0] t_word [64];

    class dict_checker #(int NODES = 16384, int SLOTS = 27, int MAXLEN = 32);
        int unsigned     links [int unsigned];
        logic [SYM_W-1:0] chars [int unsigned];
        bit              ends  [int unsigned];
        int unsigned     cursor;
        int unsigned     free_next;
        bit              dropped;
        int unsigned     char_cnt;
        int unsigned     len_cap;
        t_outcome        pending_outcomes [$];
        int              errors;

        function new();
            cursor    = 0;
            free_next = 1;
            dropped   = 0;
            char_cnt  = 0;
            errors    = 0;
            len_cap   = (MAXLEN > 63) ? 63 : MAXLEN;
        endfunction

        function int pending();
            return pending_outcomes.size();
        endfunction

        function logic [STATUS_W-1:0] walk(input logic [SYM_W-1:0] sym, input bit ins,
                                           output int unsigned dest);
            int unsigned base;
            int unsigned key;
            int unsigned fresh;
            dest = 0;
            base = cursor * SLOTS;
            for (int k = 0; k < SLOTS; k++) begin
                key = base + k;
                if (!links.exists(key)) begin
                    if (!ins) return ST_MISS;
                    if (free_next >= NODES) return ST_POOL_FULL;
                    fresh       = free_next;
                    free_next   = free_next + 1;
                    chars[fresh] = sym;
                    ends[fresh]  = 1'b0;
                    links[key]   = fresh;
                    dest         = fresh;
                    return ST_ADVANCED;
                end
                if (chars[links[key]] == sym) begin
                    dest = links[key];
                    return ST_ADVANCED;
                end
            end
            return ins ? ST_SLOTS_FULL : ST_MISS;
        endfunction

        function void accept_char(input logic func, input logic [SYM_W-1:0] sym,
                                  input logic last);
            logic [STATUS_W-1:0] st;
            int unsigned         dest;
            bit                  ins;
            t_outcome            o;
            ins = (func == FUNC_INSERT);
            if (char_cnt < len_cap) char_cnt++;
            if (dropped) begin
                st = ST_MISS;
            end else begin
                st = walk(sym, ins, dest);
                if (st == ST_ADVANCED) begin
                    cursor = dest;
                    if (ins && last) ends[dest] = 1'b1;
                    if (ends.exists(dest) && ends[dest]) st = ST_IS_WORD;
                end else begin
                    dropped = 1'b1;
                end
            end
            o.status     = st;
            o.prefix_len = char_cnt[LEN_W-1:0];
            pending_outcomes.push_back(o);
            if (last) begin
                cursor   = 0;
                dropped  = 1'b0;
                char_cnt = 0;
            end
        endfunction

        function void match_outcome(input logic [STATUS_W-1:0] st,
                                    input logic [LEN_W-1:0] len);
            t_outcome o;
            if (pending_outcomes.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: status %0d prefix_len %0d", st, len);
                return;
            end
            o = pending_outcomes.pop_front();
            if (st !== o.status || len !== o.prefix_len) begin
                errors++;
                if (errors <= 10)
                    $display("result mismatch: status exp %0d got %0d, prefix_len exp %0d got %0d",
                             o.status, st, o.prefix_len, len);
            end
        endfunction
    endclass

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              func      = FUNC_INSERT;
    logic [SYM_W-1:0]  symbol    = '0;
    logic              last      = 1'b0;
    logic              out_stall = 1'b0;
    logic              in_stall;
    logic              out_valid;
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    prefix_len;

    dict_checker #(NODE_COUNT, EDGE_SLOTS, MAX_WORD_LEN) dict;

    int          send_idle = 0;
    int          recv_idle = 0;
    int          sent      = 0;
    int unsigned cycles    = 0;

    t_word store_w [STORE_DEPTH];
    int    store_len [STORE_DEPTH];
    int    store_n = 0;

    trie_insert_prefix_match #(
        .NODE_COUNT  (NODE_COUNT),
        .EDGE_SLOTS  (EDGE_SLOTS),
        .MAX_WORD_LEN(MAX_WORD_LEN)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_func      (func),
        .i_symbol    (symbol),
        .i_last      (last),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_status    (status),
        .o_prefix_len(prefix_len)
    );

    always #2 clk = ~clk;

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < recv_idle);
    end

    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
            dict.match_outcome(status, prefix_len);
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_char(input logic f, input logic [SYM_W-1:0] s, input logic l);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        symbol   <= s;
        last     <= l;
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
        dict.accept_char(f, s, l);
        sent++;
    endtask

    task automatic send_word(input logic f, input t_word w, input int len);
        for (int i = 0; i < len; i++)
            send_char(f, w[i], i == len - 1);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (dict.pending() != 0) @(posedge clk);
    endtask

    function automatic logic [SYM_W-1:0] rand_sym();
        if ($urandom_range(99) < 12) return SYM_W'($urandom_range(255));
        return SYM_W'(8'h61 + $urandom_range(4));
    endfunction

    function automatic int rand_len();
        if ($urandom_range(99) < 5) return $urandom_range(40, 30);
        return $urandom_range(6, 1);
    endfunction

    function automatic void store_word(input t_word w, input int len);
        int idx;
        idx = (store_n < STORE_DEPTH) ? store_n : $urandom_range(STORE_DEPTH - 1);
        if (store_n < STORE_DEPTH) store_n++;
        store_w[idx]   = w;
        store_len[idx] = len;
    endfunction

    task automatic directed();
        send_char(FUNC_QUERY, "a", 1'b1);
        send_char(FUNC_INSERT, "a", 1'b0);
        send_char(FUNC_INSERT, "b", 1'b1);
        send_char(FUNC_QUERY, "a", 1'b0);
        send_char(FUNC_QUERY, "b", 1'b1);
        send_char(FUNC_QUERY, "a", 1'b1);
        send_char(FUNC_INSERT, "a", 1'b1);
        send_char(FUNC_QUERY, "a", 1'b0);
        send_char(FUNC_QUERY, "b", 1'b0);
        send_char(FUNC_QUERY, "c", 1'b0);
        send_char(FUNC_QUERY, "d", 1'b1);
        // dropped word keeps counting
        send_char(FUNC_QUERY, "x", 1'b0);
        send_char(FUNC_QUERY, "y", 1'b0);
        send_char(FUNC_INSERT, "z", 1'b1);
        // mixed func within one word
        send_char(FUNC_INSERT, "a", 1'b0);
        send_char(FUNC_QUERY, "q", 1'b0);
        send_char(FUNC_INSERT, "r", 1'b1);
        send_char(FUNC_INSERT, 8'h00, 1'b1);
        send_char(FUNC_INSERT, 8'hff, 1'b0);
        send_char(FUNC_INSERT, 8'hff, 1'b1);
        send_char(FUNC_QUERY, 8'hff, 1'b0);
        send_char(FUNC_QUERY, 8'hff, 1'b1);
        send_char(FUNC_QUERY, 8'h00, 1'b1);
    endtask

    task automatic random_words(input int n);
        int    target;
        int    r;
        int    len;
        int    idx;
        int    plen;
        t_word w;
        logic [SYM_W-1:0] start;
        target = sent + n;
        while (sent < target) begin
            r = $urandom_range(99);
            if (r < 35 || (store_n == 0 && r < 75)) begin
                len = rand_len();
                for (int i = 0; i < len; i++) w[i] = rand_sym();
                send_word(FUNC_INSERT, w, len);
                store_word(w, len);
            end else if (r < 65) begin
                idx = $urandom_range(store_n - 1);
                w   = store_w[idx];
                len = store_len[idx];
                r   = $urandom_range(9);
                if (r < 2) begin
                    len = $urandom_range(len, 1);
                end else if (r < 4 && len < 60) begin
                    for (int i = 0; i < 3; i++) w[len + i] = rand_sym();
                    len = len + $urandom_range(3, 1);
                end
                send_word(FUNC_QUERY, w, len);
            end else if (r < 75) begin
                idx = $urandom_range(store_n - 1);
                w   = store_w[idx];
                len = store_len[idx];
                if ($urandom_range(1) && len < 60) begin
                    for (int i = 0; i < 3; i++) w[len + i] = rand_sym();
                    len = len + $urandom_range(3, 1);
                end
                send_word(FUNC_INSERT, w, len);
                store_word(w, len);
            end else if (r < 85) begin
                len = rand_len();
                for (int i = 0; i < len; i++) w[i] = rand_sym();
                send_word(FUNC_QUERY, w, len);
            end else if (r < 88) begin
                // fill one node's slot list, then miss past it
                plen = 0;
                if (store_n != 0 && $urandom_range(3) != 0) begin
                    idx  = $urandom_range(store_n - 1);
                    w    = store_w[idx];
                    plen = $urandom_range((store_len[idx] < 3) ? store_len[idx] : 3, 0);
                end
                start = SYM_W'($urandom_range(255));
                for (int j = 0; j < 30; j++) begin
                    w[plen] = start + SYM_W'(j);
                    send_word(FUNC_INSERT, w, plen + 1);
                end
                w[plen] = start + SYM_W'(31);
                send_word(FUNC_QUERY, w, plen + 1);
            end else begin
                len = $urandom_range(8, 1);
                for (int i = 0; i < len; i++)
                    send_char(logic'($urandom_range(1)), SYM_W'($urandom_range(255)),
                              (i == len - 1) || ($urandom_range(9) == 0));
            end
        end
    endtask

    initial begin
        dict = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle = 22;
        recv_idle = 68;
        directed();
        wait_drained();
        random_words(300);
        wait_drained();

        send_idle = 68;
        recv_idle = 22;
        random_words(300);
        wait_drained();

        send_idle = 0;
        recv_idle = 0;
        random_words(250);

        send_idle = 22;
        recv_idle = 68;
        random_words(40);

        wait_drained();
        repeat (2 * EDGE_SLOTS + 8) @(posedge clk);
        if (dict.errors == 0 && dict.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== trie_insert_prefix_match.f =====
design/tipm_pkg.sv
design/tipm_ctrl.sv
design/tipm_dpath.sv
design/trie_insert_prefix_match.sv
tb/sv/trie_insert_prefix_match_tb.sv
